FILE: rtl/srqfc_pkg.sv
// Shared types and constants for the serial receive qualify and flow control block.
// No dependencies; every other file imports this package.
package srqfc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [7:0] CH_XON    = 8'h11;
   localparam logic [7:0] CH_XOFF   = 8'h13;
   localparam logic [7:0] CH_MARK   = 8'hFF;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [6:0] LOW7_XON  = 7'h11;
   localparam logic [6:0] LOW7_XOFF = 7'h13;

   typedef enum logic [3:0] {
      OP_RX_CHAR     = 4'd0,
      OP_TX_EMPTY    = 4'd1,
      OP_OUTPUT      = 4'd2,
      OP_SUSPEND     = 4'd3,
      OP_RESUME      = 4'd4,
      OP_BLOCK       = 4'd5,
      OP_UNBLOCK     = 4'd6,
      OP_RX_FLUSH    = 4'd7,
      OP_BREAK_START = 4'd8,
      OP_TIMER       = 4'd9
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IXON         = 3'd0,
      CSR_IXANY        = 3'd1,
      CSR_PARITY_CHECK = 3'd2,
      CSR_IGNORE_BREAK = 3'd3,
      CSR_BREAK_INT    = 3'd4,
      CSR_IGNORE_PAR   = 3'd5,
      CSR_MARK_ERRORS  = 3'd6,
      CSR_STRIP        = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_RX_BYTE = 2'd0,
      KIND_TX_BYTE = 2'd1,
      KIND_BREAK   = 2'd2
   } kind_type;

   // What the receive side of one request leaves for the back end
   typedef enum logic [2:0] {
      RX_NONE   = 3'd0,
      RX_BYTE   = 3'd1,
      RX_BREAK  = 3'd2,
      RX_MARK   = 3'd3,
      RX_DOUBLE = 3'd4
   } rx_action_type;

   typedef struct packed {
      logic [3:0] operation;
      logic [7:0] rx_byte;
      logic       data_ready;
      logic       parity_error;
      logic       overrun_error;
      logic       framing_error;
      logic       break_detect;
      logic       tx_available;
      logic [7:0] tx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       from_queue;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic ixon_enable;
      logic ixany_enable;
      logic parity_check_enable;
      logic ignore_break;
      logic break_interrupt;
      logic ignore_parity_errors;
      logic mark_errors;
      logic strip_high_bit;
   } cfg_type;

   typedef struct packed {
      logic output_stopped;
      logic transmitter_busy;
      logic break_timeout;
      logic input_blocked;
      logic xoff_pending;
      logic xon_pending;
   } flags_type;

   typedef struct packed {
      logic          tx_valid;
      logic [7:0]    tx_byte;
      logic          tx_from_queue;
      rx_action_type rx_action;
      logic [7:0]    rx_byte;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/srqfc_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on srqfc_pkg for the payload types.
interface srqfc_req_if import srqfc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface srqfc_rsp_if import srqfc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/serial_rx_qualify_flow_control.sv
// Top level of the serial receive qualify and flow control engine.
// Depends on srqfc_pkg, srqfc_if, srqfc_front, srqfc_queue and srqfc_back.

// For each accepted request the front end updates the line flags
// (stopped, busy, break timeout, blocked, pending XON/XOFF) and turns the
// request into a queue entry; requests that cause no response end there.
// A two-entry queue feeds the back end, which presents one response per
// cycle from an output register unless rsp_chan.ready holds it back; a
// request expands into one to four responses. Requests are taken back to
// back as long as the queue has room, including while a response waits on
// rsp_chan.ready. Configuration writes through csr_wr_en/csr_index/csr_wr_data
// take effect on the next cycle and belong only to idle periods.
module serial_rx_qualify_flow_control import srqfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   srqfc_req_if.sink              req_chan,
   srqfc_rsp_if.source            rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wr_data
);

   logic             push;
   logic             pop;
   entry_type        push_entry;
   entry_type        head;
   queue_status_type q_status;

   srqfc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .push        (push),
      .entry       (push_entry)
   );

   srqfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   srqfc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

FILE: rtl/srqfc_front.sv
// Front end: config registers, line flags, request classification into queue entries.
// Depends on srqfc_pkg and srqfc_req_if.
module srqfc_front import srqfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   srqfc_req_if.sink              req,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic                   csr_wr_data,
   input  queue_status_type       q_status,
   output logic                   push,
   output entry_type              entry
);

   cfg_type   cfg_ff, cfg_in;
   flags_type flags_ff, flags_in;
   entry_type entry_in;
   logic      accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IXON:         cfg_in.ixon_enable          = csr_wr_data;
            CSR_IXANY:        cfg_in.ixany_enable         = csr_wr_data;
            CSR_PARITY_CHECK: cfg_in.parity_check_enable  = csr_wr_data;
            CSR_IGNORE_BREAK: cfg_in.ignore_break         = csr_wr_data;
            CSR_BREAK_INT:    cfg_in.break_interrupt      = csr_wr_data;
            CSR_IGNORE_PAR:   cfg_in.ignore_parity_errors = csr_wr_data;
            CSR_MARK_ERRORS:  cfg_in.mark_errors          = csr_wr_data;
            CSR_STRIP:        cfg_in.strip_high_bit       = csr_wr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_payload_type p;
      logic [7:0]      c;
      logic [6:0]      low;
      logic            err;
      logic            send_req;
      logic            flow_char;

      p         = req.payload;
      flags_in  = flags_ff;
      entry_in  = '0;
      entry_in.rx_action = RX_NONE;
      send_req  = 1'b0;
      flow_char = 1'b0;
      c         = p.data_ready ? p.rx_byte : 8'h00;
      low       = c[6:0];
      err       = (p.parity_error && cfg_ff.parity_check_enable) || p.overrun_error
                  || p.framing_error || p.break_detect;

      unique case (op_type'(p.operation))
         OP_RX_CHAR: begin
            if (cfg_ff.ixon_enable) begin
               if (flags_ff.output_stopped) begin
                  if (low == LOW7_XON || cfg_ff.ixany_enable) begin
                     flags_in.output_stopped = 1'b0;
                     send_req = 1'b1;
                  end
               end else if (low == LOW7_XOFF) begin
                  flags_in.output_stopped = 1'b1;
               end
               flow_char = (low == LOW7_XON) || (low == LOW7_XOFF);
            end
            if (p.break_detect) begin
               c = 8'h00;
            end
            if (flow_char) begin
               entry_in.rx_action = RX_NONE;
            end else if (err) begin
               if (c == 8'h00 && cfg_ff.ignore_break) begin
                  entry_in.rx_action = RX_NONE;
               end else if (c == 8'h00 && cfg_ff.break_interrupt) begin
                  entry_in.rx_action = RX_BREAK;
               end else if (c != 8'h00 && cfg_ff.ignore_parity_errors) begin
                  entry_in.rx_action = RX_NONE;
               end else if (cfg_ff.mark_errors) begin
                  entry_in.rx_action = RX_MARK;
                  entry_in.rx_byte   = c;
               end else begin
                  entry_in.rx_action = RX_BYTE;
                  entry_in.rx_byte   = CH_NUL;
               end
            end else if (cfg_ff.strip_high_bit) begin
               entry_in.rx_action = RX_BYTE;
               entry_in.rx_byte   = {1'b0, c[6:0]};
            end else if (c == CH_MARK && cfg_ff.mark_errors) begin
               entry_in.rx_action = RX_DOUBLE;
            end else begin
               entry_in.rx_action = RX_BYTE;
               entry_in.rx_byte   = c;
            end
         end
         OP_TX_EMPTY: begin
            flags_in.transmitter_busy = 1'b0;
            send_req = 1'b1;
         end
         OP_OUTPUT: send_req = 1'b1;
         OP_SUSPEND: flags_in.output_stopped = 1'b1;
         OP_RESUME: begin
            flags_in.output_stopped = 1'b0;
            send_req = 1'b1;
         end
         OP_BLOCK: begin
            flags_in.xon_pending   = 1'b0;
            flags_in.input_blocked = 1'b1;
            flags_in.xoff_pending  = 1'b1;
            send_req = 1'b1;
         end
         OP_UNBLOCK, OP_RX_FLUSH: begin
            // flush does nothing unless input is blocked
            if (op_type'(p.operation) == OP_UNBLOCK || flags_ff.input_blocked) begin
               flags_in.xoff_pending  = 1'b0;
               flags_in.input_blocked = 1'b0;
               flags_in.xon_pending   = 1'b1;
               send_req = 1'b1;
            end
         end
         OP_BREAK_START: flags_in.break_timeout = 1'b1;
         OP_TIMER: begin
            flags_in.break_timeout = 1'b0;
            send_req = 1'b1;
         end
         default: send_req = 1'b0;
      endcase

      // send XOFF first, then XON, then the queued byte
      if (send_req && !flags_in.output_stopped && !flags_in.break_timeout
          && !flags_in.transmitter_busy) begin
         if (flags_in.xoff_pending) begin
            flags_in.xoff_pending     = 1'b0;
            flags_in.transmitter_busy = 1'b1;
            entry_in.tx_valid = 1'b1;
            entry_in.tx_byte  = CH_XOFF;
         end else if (flags_in.xon_pending) begin
            flags_in.xon_pending      = 1'b0;
            flags_in.transmitter_busy = 1'b1;
            entry_in.tx_valid = 1'b1;
            entry_in.tx_byte  = CH_XON;
         end else if (p.tx_available) begin
            flags_in.transmitter_busy = 1'b1;
            entry_in.tx_valid      = 1'b1;
            entry_in.tx_byte       = p.tx_byte;
            entry_in.tx_from_queue = 1'b1;
         end
      end
   end

   assign push  = accept && (entry_in.tx_valid || entry_in.rx_action != RX_NONE);
   assign entry = entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '{strip_high_bit: 1'b1, default: 1'b0};
         flags_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            flags_ff <= flags_in;
         end
      end
   end

endmodule

FILE: rtl/srqfc_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on srqfc_pkg.
module srqfc_queue import srqfc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

endmodule

FILE: rtl/srqfc_back.sv
// Back end: expands each queue entry into one to four responses, one per cycle unless held by rsp.ready.
// Depends on srqfc_pkg and srqfc_rsp_if.
module srqfc_back import srqfc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             pop,
   srqfc_rsp_if.source      rsp
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [1:0]      step_ff, step_in;
   logic            load;
   logic [2:0]      tx_n, rx_n, total, rel;
   logic            last;

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;
   assign load        = !q_status.empty && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      tx_n = {2'b00, head.tx_valid};
      unique case (head.rx_action)
         RX_BYTE, RX_BREAK: rx_n = 3'd1;
         RX_MARK:           rx_n = 3'd3;
         RX_DOUBLE:         rx_n = 3'd2;
         default:           rx_n = 3'd0;
      endcase
      total = tx_n + rx_n;
      last  = ({1'b0, step_ff} == total - 3'd1);
      rel   = {1'b0, step_ff} - tx_n;

      rsp_data_in      = '0;
      rsp_data_in.last = last;
      if ({1'b0, step_ff} < tx_n) begin
         rsp_data_in.kind       = KIND_TX_BYTE;
         rsp_data_in.out_byte   = head.tx_byte;
         rsp_data_in.from_queue = head.tx_from_queue;
      end else begin
         unique case (head.rx_action)
            RX_BREAK: begin
               rsp_data_in.kind     = KIND_BREAK;
               rsp_data_in.out_byte = CH_NUL;
            end
            RX_MARK: begin
               rsp_data_in.kind = KIND_RX_BYTE;
               unique case (rel[1:0])
                  2'd0:    rsp_data_in.out_byte = CH_MARK;
                  2'd1:    rsp_data_in.out_byte = CH_NUL;
                  default: rsp_data_in.out_byte = head.rx_byte;
               endcase
            end
            RX_DOUBLE: begin
               rsp_data_in.kind     = KIND_RX_BYTE;
               rsp_data_in.out_byte = CH_MARK;
            end
            default: begin
               rsp_data_in.kind     = KIND_RX_BYTE;
               rsp_data_in.out_byte = head.rx_byte;
            end
         endcase
      end

      pop     = load && last;
      step_in = step_ff;
      if (load) begin
         step_in = last ? 2'd0 : step_ff + 2'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_step_idle_zero: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> step_ff == 2'd0)
      else $error("expansion step left nonzero with empty queue");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && rsp_data_ff.last)
      else $error("entry retired without a final response");

endmodule
